// File: rtl/tcbl_pkg.sv
// tcbl_pkg: shared widths, constants and types of the tile color blob locator
// used by every module under rtl, depends on nothing

package tcbl_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int CNT_W      = 11;
    localparam int SUM_W      = 21;
    localparam int NUM_COLORS = 3;
    localparam int NUM_OPS    = 2 * NUM_COLORS;
    localparam int OP_W       = 3;
    localparam int IDX_W      = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int RES_W      = 1 + 2 * POS_W;

    localparam int COORD_BITS_DEF = 10;

    // color slots, also register indexes of the threshold registers
    localparam logic [IDX_W-1:0] COLOR_RED    = 2'd0;
    localparam logic [IDX_W-1:0] COLOR_YELLOW = 2'd1;
    localparam logic [IDX_W-1:0] COLOR_GREEN  = 2'd2;

    // threshold reset values
    localparam logic [CNT_W-1:0] RED_MIN_RST    = 11'd100;
    localparam logic [CNT_W-1:0] YELLOW_MIN_RST = 11'd100;
    localparam logic [CNT_W-1:0] GREEN_MIN_RST  = 11'd80;

    // luma coefficients, scaled by 65536
    localparam int LUMA_KR   = 19595;
    localparam int LUMA_KG   = 38470;
    localparam int LUMA_KB   = 7471;
    localparam int LUMA_HALF = 32768;

    // chroma scale factors and rounding offset (half plus 384 * 65536 to stay positive)
    localparam int CHROMA_KB  = 36982;
    localparam int CHROMA_KR  = 46740;
    localparam int CHROMA_OFS = 25198592;
    // chroma values are held biased by 256
    localparam int CHROMA_BIAS = 256;

    // open color windows
    localparam int RED_CB_LO    = 90;
    localparam int RED_CB_HI    = 120;
    localparam int RED_CR_LO    = 190;
    localparam int RED_CR_HI    = 215;
    localparam int YELLOW_CB_LO = 20;
    localparam int YELLOW_CB_HI = 70;
    localparam int YELLOW_CR_LO = 130;
    localparam int YELLOW_CR_HI = 150;
    localparam int GREEN_CB_LO  = 105;
    localparam int GREEN_CB_HI  = 140;
    localparam int GREEN_CR_LO  = 50;
    localparam int GREEN_CR_HI  = 90;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic            in_ready;
        logic            div_start;
        logic            div_store;
        logic            load_out;
        logic            clear;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic last_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/tile_color_blob_locator.sv
// tile_color_blob_locator: top level, threshold registers and the controller/datapath pair
// depends on tcbl_pkg, tcbl_ctrl, tcbl_datapath (and through it tcbl_div)
//
// channel   | dir | transfer when            | contents
// ----------+-----+--------------------------+------------------------------------------
// pixel in  | in  | i_s_tvalid & o_s_tready  | tdata: blue, green, red, x, y; tlast: tile end
// result    | out | o_m_tvalid & i_m_tready  | tdata: red, yellow, green (seen, cx, cy each)
// config    | in  | i_cfg_we                 | idx 0 red, 1 yellow, 2 green min count
//
// pixels are taken one per cycle while a tile is being gathered
// after the tile-end transfer the input stalls until the result is loaded:
//   three pipeline stages drain, then one shared 21-step divider runs six times
// a finished result sits in the output register, so the next tile is taken while it waits;
//   only a second tile end with the first result still untaken holds the input longer
// synchronous active-low reset clears counts to one, sums to zero, thresholds to defaults
// the nominal tile edge is 40 pixels, but only tlast bounds a tile

module tile_color_blob_locator
    import tcbl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pix_blue[7:0], pix_green[15:8], pix_red[23:16],
                                               // pos_x[33:24], pos_y[43:34], zero fill
    input  logic                  i_s_tlast,   // tile_end
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // red_seen[0], red_cx[10:1], red_cy[20:11],
                                               // yellow_seen[21], yellow_cx[31:22],
                                               // yellow_cy[41:32], green_seen[42],
                                               // green_cx[52:43], green_cy[62:53], zero fill
    // threshold registers
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CNT_W-1:0]      i_cfg_data
);

    logic [CNT_W-1:0] r_min_cnt [NUM_COLORS];
    t_cmd             w_cmd;
    t_stat            w_stat;
    logic             w_accept;

    // threshold registers, unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cnt[COLOR_RED]    <= RED_MIN_RST;
            r_min_cnt[COLOR_YELLOW] <= YELLOW_MIN_RST;
            r_min_cnt[COLOR_GREEN]  <= GREEN_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                COLOR_RED:    r_min_cnt[COLOR_RED]    <= i_cfg_data;
                COLOR_YELLOW: r_min_cnt[COLOR_YELLOW] <= i_cfg_data;
                COLOR_GREEN:  r_min_cnt[COLOR_GREEN]  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pixel transfer
    assign w_accept   = i_s_tvalid && w_cmd.in_ready;
    assign o_s_tready = w_cmd.in_ready;

    tcbl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_last   (i_s_tlast),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    tcbl_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_min_cnt   (r_min_cnt),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

    // intake closes right after a tile end
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after tile end transfer");

    // the tile end pixel reaches the accumulators only while intake is closed
    a_last_while_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.last_done |-> !o_s_tready)
        else $error("tile end pixel drained while input open");

    // a new result only appears after a closed intake cycle
    a_result_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result raised while input was open");

    // divider finishes only while a division is being waited on
    a_div_no_load_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> !w_cmd.load_out && !w_cmd.in_ready)
        else $error("divider done outside a division");

endmodule

// File: rtl/tcbl_div.sv
// tcbl_div: restoring divider, one quotient bit per cycle
// depends on tcbl_pkg for the sum and count widths

module tcbl_div
    import tcbl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? CNT_W'(w_trial - {1'b0, r_den}) : w_trial[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/tcbl_datapath.sv
// tcbl_datapath: color conversion pipeline, per-color accumulators, divider and result register
// depends on tcbl_pkg and tcbl_div

module tcbl_datapath
    import tcbl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic                  i_last,
    input  logic [CNT_W-1:0]      i_min_cnt [NUM_COLORS],
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam logic [POS_W-1:0] POS_MASK = (COORD_BITS >= POS_W) ? {POS_W{1'b1}}
                                          : POS_W'((1 << COORD_BITS) - 1);
    localparam logic [SUM_W-1:0] AVG_MAX  = SUM_W'((1 << COORD_BITS) - 1);
    localparam int CHR_W = 11;

    // stage 1: luma products
    logic               r_s1_valid;
    logic               r_s1_last;
    logic [23:0]        r_s1_pr;
    logic [23:0]        r_s1_pg;
    logic [23:0]        r_s1_pb;
    logic [PIX_W-1:0]   r_s1_blue;
    logic [PIX_W-1:0]   r_s1_red;
    logic [POS_W-1:0]   r_s1_x;
    logic [POS_W-1:0]   r_s1_y;
    // stage 2: color differences
    logic               r_s2_valid;
    logic               r_s2_last;
    logic signed [8:0]  r_s2_db;
    logic signed [8:0]  r_s2_dr;
    logic [POS_W-1:0]   r_s2_x;
    logic [POS_W-1:0]   r_s2_y;
    // stage 3: biased chroma
    logic               r_s3_valid;
    logic               r_s3_last;
    logic [CHR_W-1:0]   r_s3_cb;
    logic [CHR_W-1:0]   r_s3_cr;
    logic [POS_W-1:0]   r_s3_x;
    logic [POS_W-1:0]   r_s3_y;

    logic [CNT_W-1:0]   r_cnt [NUM_COLORS];
    logic [SUM_W-1:0]   r_sx  [NUM_COLORS];
    logic [SUM_W-1:0]   r_sy  [NUM_COLORS];
    logic [POS_W-1:0]   r_avg [NUM_OPS];
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [24:0]        w_lsum;
    logic [PIX_W-1:0]   w_luma;
    logic signed [26:0] w_db_ext;
    logic signed [26:0] w_dr_ext;
    logic signed [26:0] w_cb_u;
    logic signed [26:0] w_cr_u;
    logic [NUM_COLORS-1:0] w_hit;
    logic [IDX_W-1:0]   w_color;
    logic [SUM_W-1:0]   w_num;
    logic [SUM_W-1:0]   w_quo;
    logic               w_div_done;
    logic [OUT_DATA_W-1:0] w_pack;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [POS_W-1:0] p);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(p);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_last;
        r_s1_pb   <= 24'(LUMA_KB) * 24'(i_data[7:0]);
        r_s1_pg   <= 24'(LUMA_KG) * 24'(i_data[15:8]);
        r_s1_pr   <= 24'(LUMA_KR) * 24'(i_data[23:16]);
        r_s1_blue <= i_data[7:0];
        r_s1_red  <= i_data[23:16];
        r_s1_x    <= i_data[33:24] & POS_MASK;
        r_s1_y    <= i_data[43:34] & POS_MASK;

        r_s2_last <= r_s1_last;
        r_s2_db   <= $signed({1'b0, r_s1_blue}) - $signed({1'b0, w_luma});
        r_s2_dr   <= $signed({1'b0, r_s1_red}) - $signed({1'b0, w_luma});
        r_s2_x    <= r_s1_x;
        r_s2_y    <= r_s1_y;

        r_s3_last <= r_s2_last;
        r_s3_cb   <= w_cb_u[26:16];
        r_s3_cr   <= w_cr_u[26:16];
        r_s3_x    <= r_s2_x;
        r_s3_y    <= r_s2_y;
    end

    // luma rounded half up, always below 2^24
    assign w_lsum = 25'(r_s1_pr) + 25'(r_s1_pg) + 25'(r_s1_pb) + 25'(LUMA_HALF);
    assign w_luma = w_lsum[23:16];

    // biased chroma, the offset keeps the sum positive
    assign w_db_ext = 27'(r_s2_db);
    assign w_dr_ext = 27'(r_s2_dr);
    assign w_cb_u   = w_db_ext * 27'(CHROMA_KB) + 27'(CHROMA_OFS);
    assign w_cr_u   = w_dr_ext * 27'(CHROMA_KR) + 27'(CHROMA_OFS);

    always_comb begin
        w_hit[COLOR_RED] =
            (r_s3_cb > CHR_W'(RED_CB_LO + CHROMA_BIAS)) &&
            (r_s3_cb < CHR_W'(RED_CB_HI + CHROMA_BIAS)) &&
            (r_s3_cr > CHR_W'(RED_CR_LO + CHROMA_BIAS)) &&
            (r_s3_cr < CHR_W'(RED_CR_HI + CHROMA_BIAS));
        w_hit[COLOR_YELLOW] =
            (r_s3_cb > CHR_W'(YELLOW_CB_LO + CHROMA_BIAS)) &&
            (r_s3_cb < CHR_W'(YELLOW_CB_HI + CHROMA_BIAS)) &&
            (r_s3_cr > CHR_W'(YELLOW_CR_LO + CHROMA_BIAS)) &&
            (r_s3_cr < CHR_W'(YELLOW_CR_HI + CHROMA_BIAS));
        w_hit[COLOR_GREEN] =
            (r_s3_cb > CHR_W'(GREEN_CB_LO + CHROMA_BIAS)) &&
            (r_s3_cb < CHR_W'(GREEN_CB_HI + CHROMA_BIAS)) &&
            (r_s3_cr > CHR_W'(GREEN_CR_LO + CHROMA_BIAS)) &&
            (r_s3_cr < CHR_W'(GREEN_CR_HI + CHROMA_BIAS));
    end

    // saturating accumulators, counts start at one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                r_cnt[c] <= CNT_W'(1);
                r_sx[c]  <= '0;
                r_sy[c]  <= '0;
            end
        end else if (r_s3_valid) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                if (w_hit[c]) begin
                    if (r_cnt[c] != {CNT_W{1'b1}}) begin
                        r_cnt[c] <= r_cnt[c] + CNT_W'(1);
                    end
                    r_sx[c] <= sat_add(r_sx[c], r_s3_x);
                    r_sy[c] <= sat_add(r_sy[c], r_s3_y);
                end
            end
        end
    end

    // operand select: op bits [2:1] pick the color, bit 0 picks row over column
    assign w_color = i_cmd.op[OP_W-1:1];
    assign w_num   = i_cmd.op[0] ? r_sy[w_color] : r_sx[w_color];

    tcbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_cnt[w_color]),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            r_avg[i_cmd.op] <= (w_quo > AVG_MAX) ? AVG_MAX[POS_W-1:0] : w_quo[POS_W-1:0];
        end
    end

    always_comb begin
        w_pack = '0;
        for (int c = 0; c < NUM_COLORS; c++) begin
            w_pack[c*RES_W]                 = (r_cnt[c] > i_min_cnt[c]);
            w_pack[c*RES_W+1 +: POS_W]       = r_avg[2*c];
            w_pack[c*RES_W+1+POS_W +: POS_W] = r_avg[2*c+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= w_pack;
        end
    end

    assign o_stat.last_done = r_s3_valid && r_s3_last;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule

// File: rtl/tcbl_ctrl.sv
// tcbl_ctrl: sequencer for pixel intake, pipeline flush, six divisions and result load
// depends on tcbl_pkg for the state, command and status types

module tcbl_ctrl
    import tcbl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        case (r_state)
            ST_ACCUM: begin
                o_cmd.in_ready = 1'b1;
                if (i_accept && i_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_stat.last_done) begin
                    n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_op == OP_W'(NUM_OPS - 1)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_op    = r_op + OP_W'(1);
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_op           = '0;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
                n_op    = '0;
            end
        endcase
    end

endmodule

// File: tb/tb_tile_color_blob_locator.sv
`timescale 1ns / 1ps
// tb_tile_color_blob_locator: self-checking bench for the tile color blob locator
// drives pixel tiles with random stalls on both streams, checks every result transfer
// against a local YCbCr window and centroid predictor; depends on tcbl_pkg and the RTL top

module tb_tile_color_blob_locator
    import tcbl_pkg::*;
;

    localparam int CLK_HALF      = 5;
    localparam int COORD_MAX     = 1023;
    localparam int TILE_EDGE     = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_PIXELS  = 100;
    localparam int PHASE_TILES   = 8;

    // register index outside the threshold bank, writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] COUNT_SAT  = '1;
    localparam logic [SUM_W-1:0] SUM_SAT    = '1;

    // stimulus pixel kinds: the three colors use the color slot numbers
    localparam int KIND_RED    = int'(COLOR_RED);
    localparam int KIND_YELLOW = int'(COLOR_YELLOW);
    localparam int KIND_GREEN  = int'(COLOR_GREEN);
    localparam int KIND_NOISE  = NUM_COLORS;

    typedef struct packed {
        logic             tile_end;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    // one color's share of a result, lowest bit first as on the result bus
    typedef struct packed {
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cx;
        logic             seen;
    } t_blob;

    typedef struct packed {
        t_blob green;
        t_blob yellow;
        t_blob red;
    } t_tile_result;

    // clock, reset and the bus signals the bench drives, all known from time zero
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic                  s_last   = 1'b0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_we   = 1'b0;
    logic [IDX_W-1:0]      cfg_idx  = '0;
    logic [CNT_W-1:0]      cfg_data = '0;

    // predictor state: thresholds and per-color tile accumulators
    logic [CNT_W-1:0] min_count  [NUM_COLORS];
    logic [CNT_W-1:0] blob_count [NUM_COLORS];
    logic [SUM_W-1:0] col_sum    [NUM_COLORS];
    logic [SUM_W-1:0] row_sum    [NUM_COLORS];

    t_pixel       pending_pixels [$];
    t_tile_result expected_tiles [$];
    t_pixel       in_flight;

    int in_gap     = 0;
    int out_gap    = 0;
    int fail_count = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    tile_color_blob_locator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // bgr to ycbcr in 16-bit fixed point, then the three open windows
    function automatic logic [NUM_COLORS-1:0] color_hits(t_pixel p);
        int r, g, b, luma, cb, cr;
        logic [NUM_COLORS-1:0] hits;
        r = p.red;
        g = p.green;
        b = p.blue;
        luma = (19595 * r + 38470 * g + 7471 * b + 32768) >>> 16;
        // round half up; a 384 offset keeps the floor on a positive number
        cb = ((36982 * (b - luma) + 32768 + (384 << 16)) >>> 16) - 256;
        cr = ((46740 * (r - luma) + 32768 + (384 << 16)) >>> 16) - 256;
        hits[COLOR_RED]    = cb > 90 && cb < 120 && cr > 190 && cr < 215;
        hits[COLOR_YELLOW] = cb > 20 && cb < 70 && cr > 130 && cr < 150;
        hits[COLOR_GREEN]  = cb > 105 && cb < 140 && cr > 50 && cr < 90;
        return hits;
    endfunction

    function automatic void clear_tile();
        for (int c = 0; c < NUM_COLORS; c++) begin
            blob_count[c] = 1;
            col_sum[c]    = '0;
            row_sum[c]    = '0;
        end
    endfunction

    // folds one accepted pixel into the tile; on tile end returns 1 with the result
    function automatic bit absorb_pixel(t_pixel p, output t_tile_result res);
        logic [NUM_COLORS-1:0] hits;
        logic [SUM_W:0]        wide;
        logic [SUM_W-1:0]      avg_x, avg_y;
        t_blob                 blob [NUM_COLORS];
        hits = color_hits(p);
        res  = '0;
        for (int c = 0; c < NUM_COLORS; c++) begin
            if (hits[c]) begin
                if (blob_count[c] != COUNT_SAT) blob_count[c] = blob_count[c] + 1'b1;
                wide = col_sum[c] + p.pos_x;
                col_sum[c] = (wide > SUM_SAT) ? SUM_SAT : wide[SUM_W-1:0];
                wide = row_sum[c] + p.pos_y;
                row_sum[c] = (wide > SUM_SAT) ? SUM_SAT : wide[SUM_W-1:0];
            end
        end
        if (!p.tile_end) return 1'b0;
        for (int c = 0; c < NUM_COLORS; c++) begin
            avg_x = col_sum[c] / blob_count[c];
            avg_y = row_sum[c] / blob_count[c];
            // only a saturated sum or count can push the average past the coordinate range
            if (avg_x > COORD_MAX) avg_x = COORD_MAX;
            if (avg_y > COORD_MAX) avg_y = COORD_MAX;
            blob[c].seen = blob_count[c] > min_count[c];
            blob[c].cx   = avg_x[POS_W-1:0];
            blob[c].cy   = avg_y[POS_W-1:0];
        end
        res.red    = blob[COLOR_RED];
        res.yellow = blob[COLOR_YELLOW];
        res.green  = blob[COLOR_GREEN];
        clear_tile();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic note_failure(string what, longint want, longint got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    task automatic check_blob(string color, t_blob want, t_blob got);
        if (got.seen !== want.seen) note_failure({color, " seen"}, want.seen, got.seen);
        if (got.cx !== want.cx) note_failure({color, " cx"}, want.cx, got.cx);
        if (got.cy !== want.cy) note_failure({color, " cy"}, want.cy, got.cy);
    endtask

    // ------------------------------------------------------------------
    // pixel driver: one transfer per handshake, random idle bursts
    // ------------------------------------------------------------------

    always @(posedge clk) begin : pixel_driver
        t_tile_result res;
        if (!rst_n) begin
            s_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (absorb_pixel(in_flight, res)) expected_tiles.push_back(res);
            end
            // only touch the bus when nothing is held or the held pixel just went
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    // idle burst: s_valid drops now and stays low while in_gap counts down
                    in_gap = $urandom_range(0, 18);
                    s_valid <= 1'b0;
                end else begin
                    in_flight = pending_pixels.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {4'b0, in_flight.pos_y, in_flight.pos_x,
                                in_flight.red, in_flight.green, in_flight.blue};
                    s_last  <= in_flight.tile_end;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compares each result transfer
    // ------------------------------------------------------------------

    always @(posedge clk) begin : result_monitor
        t_tile_result got, want;
        if (!rst_n) begin
            m_ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = m_data[NUM_COLORS*RES_W-1:0];
                if (expected_tiles.size() == 0) begin
                    note_failure("result with no tile pending, tdata", 0, m_data);
                end else begin
                    want = expected_tiles.pop_front();
                    check_blob("red", want.red, got.red);
                    check_blob("yellow", want.yellow, got.yellow);
                    check_blob("green", want.green, got.green);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pixel pixel_at(int blue, int green, int red, int x, int y, bit last);
        t_pixel p;
        p.blue     = PIX_W'(blue);
        p.green    = PIX_W'(green);
        p.red      = PIX_W'(red);
        p.pos_x    = POS_W'(x);
        p.pos_y    = POS_W'(y);
        p.tile_end = last;
        return p;
    endfunction

    // random pixel at a random position; color kinds are redrawn until they hit their window or the tries run out
    function automatic t_pixel make_pixel(int kind, bit last);
        t_pixel                p;
        logic [31:0]           rnd;
        logic [NUM_COLORS-1:0] hits;
        int                    tries;
        rnd        = $urandom;
        p          = '0;
        {p.red, p.green, p.blue} = rnd[23:0];
        p.pos_x    = POS_W'($urandom_range(0, COORD_MAX));
        p.pos_y    = POS_W'($urandom_range(0, COORD_MAX));
        p.tile_end = last;
        hits       = color_hits(p);
        tries      = 0;
        while (kind != KIND_NOISE && !hits[kind] && tries < 50000) begin
            rnd = $urandom;
            {p.red, p.green, p.blue} = rnd[23:0];
            hits = color_hits(p);
            tries++;
        end
        return p;
    endfunction

    // tile where about half the pixels are of the leading kind
    task automatic queue_tile(int len, int lead_kind);
        int kind;
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 1) ? lead_kind : $urandom_range(0, KIND_NOISE);
            pending_pixels.push_back(make_pixel(kind, i == len - 1));
        end
    endtask

    task automatic queue_run(int len, int kind, bit last);
        for (int i = 0; i < len; i++)
            pending_pixels.push_back(make_pixel(kind, last && i == len - 1));
    endtask

    task automatic write_min_count(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx < NUM_COLORS) min_count[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(int red_min, int yellow_min, int green_min);
        write_min_count(COLOR_RED, CNT_W'(red_min));
        write_min_count(COLOR_YELLOW, CNT_W'(yellow_min));
        write_min_count(COLOR_GREEN, CNT_W'(green_min));
    endtask

    // every pixel taken, every result back, then let the divider pass finish
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || s_valid || expected_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin : test_sequence
        int phase_pixels;
        int phase_tiles;
        int len;

        min_count[COLOR_RED]    = RED_MIN_RST;
        min_count[COLOR_YELLOW] = YELLOW_MIN_RST;
        min_count[COLOR_GREEN]  = GREEN_MIN_RST;
        clear_tile();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: corner pixels as one-pixel tiles
        pending_pixels.push_back(pixel_at(0, 0, 0, 0, 0, 1'b1));
        pending_pixels.push_back(pixel_at(255, 255, 255, COORD_MAX, COORD_MAX, 1'b1));
        // one pixel of each color in a short tile, counts below threshold
        pending_pixels.push_back(pixel_at(60, 40, 200, COORD_MAX, 0, 1'b0));
        queue_run(1, KIND_YELLOW, 1'b0);
        queue_run(1, KIND_GREEN, 1'b0);
        pending_pixels.push_back(pixel_at(128, 128, 128, 0, COORD_MAX, 1'b1));
        // grey tile: no color counted, averages come out zero
        pending_pixels.push_back(pixel_at(128, 128, 128, 5, 7, 1'b0));
        pending_pixels.push_back(pixel_at(128, 128, 128, 900, 3, 1'b0));
        pending_pixels.push_back(pixel_at(128, 128, 128, 17, 1000, 1'b1));
        wait_idle();

        // zero thresholds: the starting count of one already reports every color
        set_thresholds(0, 0, 0);
        write_min_count(REG_UNUSED, COUNT_SAT);
        queue_run(1, KIND_GREEN, 1'b1);
        queue_run(2, KIND_RED, 1'b1);
        wait_idle();

        // count equal to threshold stays unseen, one more is seen; green never
        set_thresholds(3, 2, int'(COUNT_SAT));
        queue_run(2, KIND_RED, 1'b0);
        pending_pixels.push_back(pixel_at(128, 128, 128, 1, 2, 1'b1));
        queue_run(3, KIND_RED, 1'b1);
        queue_run(2, KIND_YELLOW, 1'b0);
        queue_run(5, KIND_GREEN, 1'b1);
        wait_idle();

        // full-edge red tile at the far corner: the starting count of one
        // pulls the truncated average below the corner
        set_thresholds(TILE_EDGE, 0, int'(COUNT_SAT));
        for (int i = 0; i < TILE_EDGE; i++)
            pending_pixels.push_back(pixel_at(60, 40, 200, COORD_MAX, COORD_MAX,
                                              i == TILE_EDGE - 1));
        wait_idle();

        // random tiles under random thresholds; the last phase runs without idling
        for (int phase = 0; phase < 3; phase++) begin
            set_thresholds($urandom_range(0, 30), $urandom_range(0, 30),
                           $urandom_range(0, 30));
            calm = (phase == 2);
            phase_pixels = 0;
            phase_tiles  = 0;
            while (phase_pixels < PHASE_PIXELS || phase_tiles < PHASE_TILES) begin
                // mostly short tiles, now and then one near the nominal edge
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, TILE_EDGE)
                                                  : $urandom_range(1, 15);
                queue_tile(len, $urandom_range(0, KIND_NOISE));
                phase_pixels += len;
                phase_tiles++;
            end
            wait_idle();
        end

        if (fail_count == 0 && expected_tiles.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
